[rtl/cpu8alu_pkg.sv]
// Shared types and constants for the 8-bit accumulator ALU with flags.
// Holds the operation codes, the flag and request structs and the DAA constants.
// No dependencies; every other file of the block imports this package.
package cpu8alu_pkg;

  localparam int ModeWidth = 5;

  localparam logic [ModeWidth-1:0] MODE_ADD  = 5'd0;
  localparam logic [ModeWidth-1:0] MODE_ADC  = 5'd1;
  localparam logic [ModeWidth-1:0] MODE_SUB  = 5'd2;
  localparam logic [ModeWidth-1:0] MODE_SBC  = 5'd3;
  localparam logic [ModeWidth-1:0] MODE_AND  = 5'd4;
  localparam logic [ModeWidth-1:0] MODE_XOR  = 5'd5;
  localparam logic [ModeWidth-1:0] MODE_OR   = 5'd6;
  localparam logic [ModeWidth-1:0] MODE_CP   = 5'd7;
  localparam logic [ModeWidth-1:0] MODE_RLC  = 5'd8;
  localparam logic [ModeWidth-1:0] MODE_RRC  = 5'd9;
  localparam logic [ModeWidth-1:0] MODE_RL   = 5'd10;
  localparam logic [ModeWidth-1:0] MODE_RR   = 5'd11;
  localparam logic [ModeWidth-1:0] MODE_SLA  = 5'd12;
  localparam logic [ModeWidth-1:0] MODE_SRA  = 5'd13;
  localparam logic [ModeWidth-1:0] MODE_SWAP = 5'd14;
  localparam logic [ModeWidth-1:0] MODE_SRL  = 5'd15;
  localparam logic [ModeWidth-1:0] MODE_BIT  = 5'd16;
  localparam logic [ModeWidth-1:0] MODE_RES  = 5'd17;
  localparam logic [ModeWidth-1:0] MODE_SET  = 5'd18;
  localparam logic [ModeWidth-1:0] MODE_INC  = 5'd19;
  localparam logic [ModeWidth-1:0] MODE_DEC  = 5'd20;
  localparam logic [ModeWidth-1:0] MODE_DAA  = 5'd21;
  localparam logic [ModeWidth-1:0] MODE_CPL  = 5'd22;
  localparam logic [ModeWidth-1:0] MODE_SCF  = 5'd23;
  localparam logic [ModeWidth-1:0] MODE_CCF  = 5'd24;
  localparam logic [ModeWidth-1:0] MODE_RRCA = 5'd25;
  localparam logic [ModeWidth-1:0] MODE_RRA  = 5'd26;

  localparam logic [3:0] NIBBLE_MAX     = 4'hF;
  localparam logic [3:0] DAA_LOW_LIMIT  = 4'h9;
  localparam logic [7:0] DAA_HIGH_LIMIT = 8'h99;
  localparam logic [7:0] DAA_LOW_ADJ    = 8'h06;
  localparam logic [7:0] DAA_HIGH_ADJ   = 8'h60;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } alu_flags_t;

  typedef struct packed {
    logic [ModeWidth-1:0] mode;
    logic [7:0]           a;
    logic [7:0]           v;
    logic [2:0]           bi;
    alu_flags_t           flags;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] value;
    alu_flags_t flags;
  } alu_res_t;

endpackage

[rtl/cpu8alu_core.sv]
// Combinational datapath of the 8-bit ALU: one request in, one result and flags out.
// Depends on cpu8alu_pkg for operation codes, constants and structs.
module cpu8alu_core
  import cpu8alu_pkg::*;
(
  input  alu_req_t req,
  output alu_res_t res
);

  logic [8:0] sum9;
  logic [8:0] diff9;
  logic [4:0] hsum5;
  logic [4:0] hdiff5;
  logic       t;
  logic [7:0] mask;
  logic [7:0] adj;
  logic [7:0] r;
  logic [7:0] v;
  logic [7:0] a;
  logic       sc;
  alu_flags_t f;

  always_comb begin
    a      = req.a;
    v      = req.v;
    t      = (req.mode == MODE_ADC || req.mode == MODE_SBC) ? req.flags.c : 1'b0;
    sum9   = {1'b0, a} + {1'b0, v} + {8'd0, t};
    diff9  = {1'b0, a} - {1'b0, v} - {8'd0, t};
    hsum5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, t};
    hdiff5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, t};
    mask   = 8'd1 << req.bi;
    adj    = 8'd0;
    sc     = 1'b0;
    r      = a;
    f      = req.flags;

    unique case (req.mode)
      MODE_ADD, MODE_ADC: begin
        r = sum9[7:0];
        f = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        r = (req.mode == MODE_CP) ? a : diff9[7:0];
        f = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: hdiff5[4], c: diff9[8]};
      end
      MODE_AND: begin
        r = a & v;
        f = '{z: ((a & v) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      MODE_XOR: begin
        r = a ^ v;
        f = '{z: ((a ^ v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      MODE_OR: begin
        r = a | v;
        f = '{z: ((a | v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      MODE_RLC, MODE_RRC, MODE_RL, MODE_RR,
      MODE_SLA, MODE_SRA, MODE_SWAP, MODE_SRL: begin
        unique case (req.mode)
          MODE_RLC: begin
            sc = v[7];
            r  = {v[6:0], v[7]};
          end
          MODE_RRC: begin
            sc = v[0];
            r  = {v[0], v[7:1]};
          end
          MODE_RL: begin
            sc = v[7];
            r  = {v[6:0], req.flags.c};
          end
          MODE_RR: begin
            sc = v[0];
            r  = {req.flags.c, v[7:1]};
          end
          MODE_SLA: begin
            sc = v[7];
            r  = {v[6:0], 1'b0};
          end
          MODE_SRA: begin
            sc = v[0];
            r  = {v[7], v[7:1]};
          end
          MODE_SWAP: begin
            sc = 1'b0;
            r  = {v[3:0], v[7:4]};
          end
          default: begin
            sc = v[0];
            r  = {1'b0, v[7:1]};
          end
        endcase
        f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: sc};
      end
      MODE_BIT: begin
        r   = v;
        f.z = ~v[req.bi];
        f.n = 1'b0;
        f.h = 1'b1;
      end
      MODE_RES: r = v & ~mask;
      MODE_SET: r = v | mask;
      MODE_INC: begin
        r   = v + 8'd1;
        f.z = (v == 8'hFF);
        f.n = 1'b0;
        f.h = (v[3:0] == NIBBLE_MAX);
      end
      MODE_DEC: begin
        r   = v - 8'd1;
        f.z = (v == 8'd1);
        f.n = 1'b1;
        f.h = (v[3:0] == 4'd0);
      end
      MODE_DAA: begin
        if (!req.flags.n) begin
          if (req.flags.h || a[3:0] > DAA_LOW_LIMIT) begin
            adj = adj | DAA_LOW_ADJ;
          end
          if (req.flags.c || a > DAA_HIGH_LIMIT) begin
            adj = adj | DAA_HIGH_ADJ;
            f.c = 1'b1;
          end
          r = a + adj;
        end else begin
          if (req.flags.h) begin
            adj = adj | DAA_LOW_ADJ;
          end
          if (req.flags.c) begin
            adj = adj | DAA_HIGH_ADJ;
          end
          r = a - adj;
        end
        f.z = (r == 8'd0);
        f.h = 1'b0;
      end
      MODE_CPL: begin
        r   = ~a;
        f.n = 1'b1;
        f.h = 1'b1;
      end
      MODE_SCF: begin
        f.n = 1'b0;
        f.h = 1'b0;
        f.c = 1'b1;
      end
      MODE_CCF: begin
        f.n = 1'b0;
        f.h = 1'b0;
        f.c = ~req.flags.c;
      end
      MODE_RRCA: begin
        r = {a[0], a[7:1]};
        f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      MODE_RRA: begin
        r = {req.flags.c, a[7:1]};
        f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      default: begin
        r = a;
      end
    endcase

    res.value = r;
    res.flags = f;
  end

endmodule

[rtl/cpu8_alu_with_flags_top.sv]
// An accepted request is captured in the input register and its result in the result register.
// Throughput: one request per cycle while req_stall is low; an input register and a result register
// form a two-entry pipeline, so a request is taken while a result waits.
// Reset (synchronous, active high) clears both stage valid bits; payload is not reset.
// Depends on cpu8alu_pkg and cpu8alu_core.
module cpu8_alu_with_flags_top
  import cpu8alu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [ModeWidth-1:0] mode,
  input  logic [7:0]           accumulator,
  input  logic [7:0]           operand,
  input  logic [2:0]           bit_index,
  input  logic                 zero_in,
  input  logic                 subtract_in,
  input  logic                 half_in,
  input  logic                 carry_in,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [7:0]           result,
  output logic                 zero_out,
  output logic                 subtract_out,
  output logic                 half_out,
  output logic                 carry_out
);

  logic     stage_valid;
  alu_req_t stage_req;
  alu_res_t stage_res;
  alu_res_t res_q;
  logic     advance;

  assign advance   = !res_valid || !res_stall;
  assign req_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!req_stall) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      stage_req <= '{mode: mode, a: accumulator, v: operand, bi: bit_index,
                     flags: '{z: zero_in, n: subtract_in, h: half_in, c: carry_in}};
    end
  end

  cpu8alu_core u_core (
    .req (stage_req),
    .res (stage_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      res_q <= stage_res;
    end
  end

  assign result       = res_q.value;
  assign zero_out     = res_q.flags.z;
  assign subtract_out = res_q.flags.n;
  assign half_out     = res_q.flags.h;
  assign carry_out    = res_q.flags.c;

endmodule

[rtl/cpu8alu_checker.sv]
// Port-level checks for the ALU top level, attached by the bind below.
// Depends on cpu8alu_pkg for the mode width only.
module cpu8alu_checker
  import cpu8alu_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input logic [ModeWidth-1:0] mode,
  input logic [7:0]           accumulator,
  input logic [7:0]           operand,
  input logic [2:0]           bit_index,
  input logic                 zero_in,
  input logic                 subtract_in,
  input logic                 half_in,
  input logic                 carry_in,
  input logic                 res_valid,
  input logic                 res_stall,
  input logic [7:0]           result,
  input logic                 zero_out,
  input logic                 subtract_out,
  input logic                 half_out,
  input logic                 carry_out
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result valid after reset.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> res_valid && res_stall)
    else $error("Request stalled while the result side was free.");

  a_two_cycle_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) ##1 !res_stall |=> res_valid)
    else $error("Accepted request did not reach the result in two cycles.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(result) && $stable(zero_out)
      && $stable(subtract_out) && $stable(half_out) && $stable(carry_out))
    else $error("Stalled result changed.");

  a_request_held: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(mode) && $stable(accumulator)
      && $stable(operand) && $stable(bit_index) && $stable(zero_in)
      && $stable(subtract_in) && $stable(half_in) && $stable(carry_in))
    else $error("Stalled request changed.");

endmodule

bind cpu8_alu_with_flags_top cpu8alu_checker u_checker (.*);

[verif/tb_top.sv]
// Self-checking testbench for the 8-bit accumulator ALU with flags.
// Directed and random requests go through the valid/stall ports; an in-bench model
// predicts every result. Depends on cpu8alu_pkg and cpu8_alu_with_flags_top.
module tb_top;
  import cpu8alu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 2000;
  localparam int TailCycles = 4;
  localparam int MaxPrinted = 40;
  localparam logic [ModeWidth-1:0] ModeUnused = 5'd31;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  logic [ModeWidth-1:0] mode;
  logic [7:0]           accumulator;
  logic [7:0]           operand;
  logic [2:0]           bit_index;
  logic                 zero_in;
  logic                 subtract_in;
  logic                 half_in;
  logic                 carry_in;
  logic                 res_valid;
  logic                 res_stall;
  logic [7:0]           result;
  logic                 zero_out;
  logic                 subtract_out;
  logic                 half_out;
  logic                 carry_out;

  alu_res_t pending_results[$];
  int       mismatches = 0;
  int       requests_sent = 0;
  int       results_checked = 0;
  int       idle_cycles = 0;
  int       stall_left = 0;
  bit       send_idling = 1'b1;
  bit       recv_idling = 1'b1;
  bit       mode_seen[32];

  cpu8_alu_with_flags_top uut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .mode         (mode),
    .accumulator  (accumulator),
    .operand      (operand),
    .bit_index    (bit_index),
    .zero_in      (zero_in),
    .subtract_in  (subtract_in),
    .half_in      (half_in),
    .carry_in     (carry_in),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result       (result),
    .zero_out     (zero_out),
    .subtract_out (subtract_out),
    .half_out     (half_out),
    .carry_out    (carry_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic alu_res_t alu_compute(input alu_req_t rq);
    alu_res_t   rs;
    logic [8:0] wide;
    logic [4:0] nib;
    logic [7:0] adj;
    logic       t;
    rs.value = rq.a;
    rs.flags = rq.flags;
    t = 1'b0;
    case (rq.mode)
      MODE_ADD, MODE_ADC: begin
        if (rq.mode == MODE_ADC) t = rq.flags.c;
        wide = {1'b0, rq.a} + {1'b0, rq.v} + {8'd0, t};
        nib = {1'b0, rq.a[3:0]} + {1'b0, rq.v[3:0]} + {4'd0, t};
        rs.value = wide[7:0];
        rs.flags = '{z: wide[7:0] == 8'h00, n: 1'b0, h: nib[4], c: wide[8]};
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        if (rq.mode == MODE_SBC) t = rq.flags.c;
        wide = {1'b0, rq.a} - {1'b0, rq.v} - {8'd0, t};
        nib = {1'b0, rq.a[3:0]} - {1'b0, rq.v[3:0]} - {4'd0, t};
        rs.value = (rq.mode == MODE_CP) ? rq.a : wide[7:0];
        rs.flags = '{z: wide[7:0] == 8'h00, n: 1'b1, h: nib[4], c: wide[8]};
      end
      MODE_AND: begin
        rs.value = rq.a & rq.v;
        rs.flags = '{z: rs.value == 8'h00, n: 1'b0, h: 1'b1, c: 1'b0};
      end
      MODE_XOR: begin
        rs.value = rq.a ^ rq.v;
        rs.flags = '{z: rs.value == 8'h00, n: 1'b0, h: 1'b0, c: 1'b0};
      end
      MODE_OR: begin
        rs.value = rq.a | rq.v;
        rs.flags = '{z: rs.value == 8'h00, n: 1'b0, h: 1'b0, c: 1'b0};
      end
      MODE_RLC, MODE_RRC, MODE_RL, MODE_RR, MODE_SLA, MODE_SRA, MODE_SWAP, MODE_SRL: begin
        case (rq.mode)
          MODE_RLC: begin
            t = rq.v[7];
            rs.value = {rq.v[6:0], rq.v[7]};
          end
          MODE_RRC: begin
            t = rq.v[0];
            rs.value = {rq.v[0], rq.v[7:1]};
          end
          MODE_RL: begin
            t = rq.v[7];
            rs.value = {rq.v[6:0], rq.flags.c};
          end
          MODE_RR: begin
            t = rq.v[0];
            rs.value = {rq.flags.c, rq.v[7:1]};
          end
          MODE_SLA: begin
            t = rq.v[7];
            rs.value = {rq.v[6:0], 1'b0};
          end
          MODE_SRA: begin
            t = rq.v[0];
            rs.value = {rq.v[7], rq.v[7:1]};
          end
          MODE_SWAP: begin
            t = 1'b0;
            rs.value = {rq.v[3:0], rq.v[7:4]};
          end
          default: begin
            t = rq.v[0];
            rs.value = {1'b0, rq.v[7:1]};
          end
        endcase
        rs.flags = '{z: rs.value == 8'h00, n: 1'b0, h: 1'b0, c: t};
      end
      MODE_BIT: begin
        rs.value = rq.v;
        rs.flags.z = ~rq.v[rq.bi];
        rs.flags.n = 1'b0;
        rs.flags.h = 1'b1;
      end
      MODE_RES: rs.value = rq.v & ~(8'h01 << rq.bi);
      MODE_SET: rs.value = rq.v | (8'h01 << rq.bi);
      MODE_INC: begin
        rs.value = rq.v + 8'h01;
        rs.flags.z = rs.value == 8'h00;
        rs.flags.n = 1'b0;
        rs.flags.h = rq.v[3:0] == 4'hF;
      end
      MODE_DEC: begin
        rs.value = rq.v - 8'h01;
        rs.flags.z = rs.value == 8'h00;
        rs.flags.n = 1'b1;
        rs.flags.h = rq.v[3:0] == 4'h0;
      end
      MODE_DAA: begin
        adj = 8'h00;
        if (!rq.flags.n) begin
          if (rq.flags.h || rq.a[3:0] > 4'h9) adj |= 8'h06;
          if (rq.flags.c || rq.a > 8'h99) begin
            adj |= 8'h60;
            rs.flags.c = 1'b1;
          end
          rs.value = rq.a + adj;
        end else begin
          if (rq.flags.h) adj |= 8'h06;
          if (rq.flags.c) adj |= 8'h60;
          rs.value = rq.a - adj;
        end
        rs.flags.z = rs.value == 8'h00;
        rs.flags.h = 1'b0;
      end
      MODE_CPL: begin
        rs.value = ~rq.a;
        rs.flags.n = 1'b1;
        rs.flags.h = 1'b1;
      end
      MODE_SCF: rs.flags = '{z: rq.flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
      MODE_CCF: rs.flags = '{z: rq.flags.z, n: 1'b0, h: 1'b0, c: ~rq.flags.c};
      MODE_RRCA: begin
        rs.value = {rq.a[0], rq.a[7:1]};
        rs.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: rq.a[0]};
      end
      MODE_RRA: begin
        rs.value = {rq.flags.c, rq.a[7:1]};
        rs.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: rq.a[0]};
      end
      default: ;
    endcase
    return rs;
  endfunction

  function automatic int pick_gap(input bit enabled);
    int roll;
    roll = $urandom_range(0, 99);
    if (!enabled || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t: mismatch on %s after %0d results: got 0x%0h, expected 0x%0h",
               $time, field, results_checked, got, want);
  endtask

  task automatic send_req(input logic [ModeWidth-1:0] m, input logic [7:0] a,
                          input logic [7:0] v, input logic [2:0] bi,
                          input alu_flags_t fl);
    alu_req_t rq;
    int       gap;
    rq = '{mode: m, a: a, v: v, bi: bi, flags: fl};
    mode        <= rq.mode;
    accumulator <= rq.a;
    operand     <= rq.v;
    bit_index   <= rq.bi;
    zero_in     <= rq.flags.z;
    subtract_in <= rq.flags.n;
    half_in     <= rq.flags.h;
    carry_in    <= rq.flags.c;
    req_valid   <= 1'b1;
    forever begin
      @(negedge clk);
      if (!req_stall) break;
    end
    pending_results.push_back(alu_compute(rq));
    requests_sent++;
    mode_seen[m] = 1'b1;
    @(posedge clk);
    gap = pick_gap(send_idling);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_req();
    logic [ModeWidth-1:0] m;
    if ($urandom_range(0, 99) < 94) begin
      m = ModeWidth'($urandom_range(int'(MODE_ADD), int'(MODE_RRA)));
    end else begin
      m = ModeWidth'($urandom_range(int'(MODE_RRA) + 1, int'(ModeUnused)));
    end
    send_req(m, 8'($urandom), 8'($urandom), 3'($urandom), 4'($urandom));
  endtask

  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_arith();
    send_req(MODE_ADD, 8'hFF, 8'h01, 3'd0, 4'b0000);
    send_req(MODE_ADC, 8'h0F, 8'h00, 3'd0, 4'b0001);
    send_req(MODE_SUB, 8'h10, 8'h01, 3'd0, 4'b1000);
    send_req(MODE_SBC, 8'h00, 8'hFF, 3'd0, 4'b0001);
    send_req(MODE_CP, 8'h42, 8'h42, 3'd0, 4'b0000);
  endtask

  task automatic test_logic();
    send_req(MODE_AND, 8'hF0, 8'h0F, 3'd0, 4'b0111);
    send_req(MODE_XOR, 8'hFF, 8'hFF, 3'd0, 4'b0111);
    send_req(MODE_OR, 8'hA5, 8'h5A, 3'd0, 4'b1111);
  endtask

  task automatic test_shifts();
    send_req(MODE_RLC, 8'h00, 8'h81, 3'd0, 4'b0000);
    send_req(MODE_RRC, 8'h00, 8'h81, 3'd0, 4'b0000);
    send_req(MODE_RL, 8'h00, 8'h80, 3'd0, 4'b1111);
    send_req(MODE_RR, 8'h00, 8'h01, 3'd0, 4'b1111);
    send_req(MODE_SLA, 8'h00, 8'h80, 3'd0, 4'b0110);
    send_req(MODE_SRA, 8'h00, 8'hC1, 3'd0, 4'b0000);
    send_req(MODE_SWAP, 8'h00, 8'hF0, 3'd0, 4'b0001);
    send_req(MODE_SRL, 8'h00, 8'hFF, 3'd0, 4'b1110);
  endtask

  task automatic test_bit_ops();
    send_req(MODE_BIT, 8'h00, 8'h7F, 3'd7, 4'b0101);
    send_req(MODE_RES, 8'h00, 8'hFF, 3'd0, 4'b1010);
    send_req(MODE_SET, 8'h00, 8'h00, 3'd7, 4'b0101);
  endtask

  task automatic test_inc_dec();
    send_req(MODE_INC, 8'h00, 8'hFF, 3'd0, 4'b0101);
    send_req(MODE_DEC, 8'h00, 8'h00, 3'd0, 4'b1010);
  endtask

  // Decimal adjust after an add and after a subtract, the complement, the flag-only
  // operations, the accumulator rotates and an unused opcode.
  task automatic test_accum_misc();
    send_req(MODE_DAA, 8'h9A, 8'h00, 3'd0, 4'b0000);
    send_req(MODE_DAA, 8'h00, 8'h00, 3'd0, 4'b0111);
    send_req(MODE_CPL, 8'h00, 8'h00, 3'd0, 4'b1000);
    send_req(MODE_SCF, 8'hAA, 8'h00, 3'd0, 4'b1110);
    send_req(MODE_CCF, 8'h55, 8'h00, 3'd0, 4'b0111);
    send_req(MODE_RRCA, 8'h01, 8'h00, 3'd0, 4'b1110);
    send_req(MODE_RRA, 8'h01, 8'h00, 3'd0, 4'b0000);
    send_req(ModeUnused, 8'h3C, 8'hC3, 3'd5, 4'b1011);
  endtask

  task automatic test_back_to_back(input int count);
    send_idling = 1'b0;
    recv_idling = 1'b0;
    repeat (count) send_random_req();
    send_idling = 1'b1;
    recv_idling = 1'b1;
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_random_req();
  endtask

  task automatic test_drain_pause(input int count);
    repeat (count) send_random_req();
    wait_for_drain();
    repeat (count) send_random_req();
  endtask

  initial begin
    rst         <= 1'b1;
    req_valid   <= 1'b0;
    mode        <= '0;
    accumulator <= '0;
    operand     <= '0;
    bit_index   <= '0;
    zero_in     <= 1'b0;
    subtract_in <= 1'b0;
    half_in     <= 1'b0;
    carry_in    <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_arith();
    test_logic();
    test_shifts();
    test_bit_ops();
    test_inc_dec();
    test_accum_misc();
    test_back_to_back(120);
    test_random_traffic(200);
    test_drain_pause(50);
    recv_idling = 1'b0;
    test_random_traffic(50);
    recv_idling = 1'b1;
    send_idling = 1'b0;
    test_random_traffic(50);
    send_idling = 1'b1;
    wait_for_drain();
    repeat (TailCycles) @(posedge clk);
    $display("Sent %0d requests covering %0d of 32 opcodes; %0d results checked, %0d mismatches.",
             requests_sent, mode_seen.sum() with (int'(item)), results_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        stall_left = pick_gap(recv_idling);
        if (stall_left > 0) begin
          stall_left--;
          res_stall <= 1'b1;
        end else begin
          res_stall <= 1'b0;
        end
      end
    end
  end

  // Outputs and both stall signals change only at the rising edge, so values
  // seen at the falling edge decide what the next rising edge accepts.
  initial begin
    alu_res_t want;
    forever begin
      @(negedge clk);
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (!rst && res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", int'(result), 0);
        end else begin
          want = pending_results.pop_front();
          if (result !== want.value)
            report_mismatch("result", int'(result), int'(want.value));
          if (zero_out !== want.flags.z)
            report_mismatch("zero", int'(zero_out), int'(want.flags.z));
          if (subtract_out !== want.flags.n)
            report_mismatch("subtract", int'(subtract_out), int'(want.flags.n));
          if (half_out !== want.flags.h)
            report_mismatch("half carry", int'(half_out), int'(want.flags.h));
          if (carry_out !== want.flags.c)
            report_mismatch("carry", int'(carry_out), int'(want.flags.c));
        end
        results_checked++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no request or result moved for %0d cycles, %0d results outstanding.",
                 idle_cycles, pending_results.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

endmodule

[cpu8_alu_with_flags_top.f]
rtl/cpu8alu_pkg.sv
rtl/cpu8alu_core.sv
rtl/cpu8_alu_with_flags_top.sv
rtl/cpu8alu_checker.sv
verif/tb_top.sv
